@@ rtl/pdd_pkg.sv @@
// Shared types, state codes and the signature decode table for the port device id detector.
// Used by every RTL module and by the checker; depends on nothing.
package pdd_pkg;

	localparam int PATTERN_COUNT = 9;
	localparam int SIG_W         = 21;
	localparam int RX_OFFSET     = 12;

	localparam logic [11:0]      MARGINAL_LOW = 12'h024;
	localparam logic [SIG_W-1:0] BUTTON_SIG   = 21'h03f00f;
	localparam logic [3:0]       BUTTON_ID    = 4'd5;
	localparam logic [3:0]       NO_ID        = 4'd0;
	localparam logic [3:0]       MAX_ID       = 4'd11;

	// Pin 6 modes.
	localparam logic [1:0] P6_DRIVE_HIGH = 2'd0;
	localparam logic [1:0] P6_PULLUP     = 2'd1;
	localparam logic [1:0] P6_DRIVE_LOW  = 2'd2;
	localparam logic [1:0] P6_INPUT      = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_SETTLE     = 2'd0;
	localparam logic [1:0] REG_REPOLL     = 2'd1;
	localparam logic [1:0] REG_MATCH      = 2'd2;
	localparam logic [1:0] REG_ACTIVE_HLD = 2'd3;

	typedef enum logic [2:0] {
		ST_START      = 3'd0,
		ST_DRIVE      = 3'd1,
		ST_SAMPLE     = 3'd2,
		ST_DECODE     = 3'd3,
		ST_ACT_SETUP  = 3'd4,
		ST_ACT_HOLD   = 3'd5,
		ST_ACT_ACCEPT = 3'd6,
		ST_HANDOFF    = 3'd7
	} pdd_step_t;

	typedef struct packed {
		logic [2:0] elapsed_ms;
		logic       pin5_level;
		logic       rx_level;
		logic       pin6_level;
		logic       restart_detect;
	} pdd_in_t;

	typedef struct packed {
		logic       tx_drive_level;
		logic       pin5_driver_on;
		logic       pin5_pullup;
		logic [1:0] pin6_mode;
		logic [3:0] device_id;
		logic       connected;
		logic       button_pressed;
		logic       active_handoff;
	} pdd_out_t;

	typedef struct packed {
		logic [3:0] settle_ms;
		logic [7:0] repoll_ms;
		logic [2:0] match_target;
		logic [7:0] active_hold_ms;
	} pdd_cfg_t;

	typedef struct packed {
		pdd_step_t        step;
		logic [7:0]       wait_left;
		logic [3:0]       pattern_index;
		logic [2:0]       match_count;
		logic [SIG_W-1:0] signature;
		logic [3:0]       current_id;
		logic             connected;
		logic             button;
		logic [7:0]       hold_timer;
		logic             tx;
		logic             drv;
		logic             pu;
		logic [1:0]       p6_mode;
	} pdd_state_t;

	// Decoder result: a passive id, or the float signature that calls for an active check.
	typedef struct packed {
		logic [3:0] id;
		logic       is_float;
	} pdd_id_t;

	function automatic pdd_id_t pdd_lookup(input logic [SIG_W-1:0] sig);
		pdd_id_t r;
		r.is_float = 1'b0;
		unique case (sig)
			21'h0f303f: r.id = 4'd0;
			21'h038007: r.id = 4'd1;
			21'h0381ff: r.id = 4'd2;
			21'h1c7000: r.id = 4'd3;
			21'h038000: r.id = 4'd4;
			21'h03f01f: r.id = 4'd5;
			21'h03f00f: r.id = 4'd5;
			21'h1ff1ff: r.id = 4'd6;
			21'h1c7007: r.id = 4'd7;
			21'h0e3007: r.id = 4'd8;
			21'h0fb1ff: r.id = 4'd9;
			21'h0c3000: r.id = 4'd10;
			21'h000024: r.id = 4'd11;
			21'h03803f: begin
				r.id       = NO_ID;
				r.is_float = 1'b1;
			end
			default:    r.id = NO_ID;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/pdd_decode.sv @@
// Signature decoder: clears marginal receive bits and maps the signature to a device id.
// Depends on pdd_pkg.
module pdd_decode (
	input  logic [pdd_pkg::SIG_W-1:0] sig,
	output logic [pdd_pkg::SIG_W-1:0] sig_clean,
	output pdd_pkg::pdd_id_t          id
);
	import pdd_pkg::*;

	// A signature whose low half is the marginal pattern loses its receive bits.
	always_comb begin
		if (sig[11:0] == MARGINAL_LOW) begin
			sig_clean = {{(SIG_W-12){1'b0}}, sig[11:0]};
		end else begin
			sig_clean = sig;
		end
		id = pdd_lookup(sig_clean);
	end

endmodule

@@ rtl/pdd_step.sv @@
// Next-state logic of the detector for one input word.
// Depends on pdd_pkg and pdd_decode.
module pdd_step (
	input  pdd_pkg::pdd_state_t cur,
	input  pdd_pkg::pdd_in_t    item,
	input  pdd_pkg::pdd_cfg_t   cfg,
	output pdd_pkg::pdd_state_t nxt
);
	import pdd_pkg::*;

	logic [SIG_W-1:0] sig_clean;
	pdd_id_t          dec;

	pdd_decode u_decode (
		.sig       (cur.signature),
		.sig_clean (sig_clean),
		.id        (dec)
	);

	always_comb begin
		pdd_state_t  s;
		logic [8:0]  hold_sum;
		logic [3:0]  pi;
		logic [1:0]  row;
		logic [1:0]  col;
		logic [23:0] sig_ext;
		logic [4:0]  rx_pos;

		s = cur;
		s.wait_left = (cur.wait_left > {5'd0, item.elapsed_ms}) ?
			cur.wait_left - {5'd0, item.elapsed_ms} : 8'd0;
		hold_sum    = {1'b0, cur.hold_timer} + {6'd0, item.elapsed_ms};
		s.hold_timer = hold_sum[8] ? 8'hff : hold_sum[7:0];

		pi      = cur.pattern_index;
		sig_ext = '0;
		rx_pos  = '0;
		row     = 2'd3;
		col     = 2'd0;

		if (s.wait_left == 8'd0) begin
			unique case (cur.step)
				ST_START, ST_DRIVE: begin
					if (cur.step == ST_START) begin
						s.signature     = '0;
						s.pattern_index = '0;
						s.pu            = 1'b1;
						pi              = '0;
					end
					// Row picks the pin 5 level, column the pin 6 mode; row 3 leaves pin 5 as is.
					unique case (pi)
						4'd0:  begin row = 2'd0; col = 2'd0; end
						4'd1:  begin row = 2'd0; col = 2'd1; end
						4'd2:  begin row = 2'd0; col = 2'd2; end
						4'd3:  begin row = 2'd1; col = 2'd0; end
						4'd4:  begin row = 2'd1; col = 2'd1; end
						4'd5:  begin row = 2'd1; col = 2'd2; end
						4'd6:  begin row = 2'd2; col = 2'd0; end
						4'd7:  begin row = 2'd2; col = 2'd1; end
						4'd8:  begin row = 2'd2; col = 2'd2; end
						4'd9:  begin row = 2'd3; col = 2'd0; end
						4'd10: begin row = 2'd3; col = 2'd1; end
						4'd11: begin row = 2'd3; col = 2'd2; end
						4'd12: begin row = 2'd3; col = 2'd0; end
						4'd13: begin row = 2'd3; col = 2'd1; end
						4'd14: begin row = 2'd3; col = 2'd2; end
						default: begin row = 2'd3; col = 2'd0; end
					endcase
					unique case (row)
						2'd0: begin
							s.tx  = 1'b1;
							s.drv = 1'b1;
						end
						2'd1: s.drv = 1'b0;
						2'd2: begin
							s.tx  = 1'b0;
							s.drv = 1'b1;
						end
						default: ;
					endcase
					s.p6_mode   = col;
					s.wait_left = {4'd0, cfg.settle_ms};
					s.step      = ST_SAMPLE;
				end
				ST_SAMPLE: begin
					if (pi < 4'd12) begin
						rx_pos  = {1'b0, pi} + 5'(RX_OFFSET);
						sig_ext = {3'd0, cur.signature}
							| ({23'd0, item.pin5_level} << pi)
							| ({23'd0, item.rx_level} << rx_pos);
						s.signature = sig_ext[SIG_W-1:0];
					end
					s.pattern_index = pi + 4'd1;
					s.step = (s.pattern_index < 4'(PATTERN_COUNT)) ? ST_DRIVE : ST_DECODE;
				end
				ST_DECODE: begin
					s.drv       = 1'b0;
					s.pu        = 1'b0;
					s.p6_mode   = P6_INPUT;
					s.signature = sig_clean;
					if (dec.is_float) begin
						s.step = ST_ACT_SETUP;
					end else begin
						s.step      = ST_START;
						s.wait_left = cfg.repoll_ms;
						if ((cur.current_id != NO_ID && dec.id != cur.current_id)
							|| dec.id == NO_ID) begin
							s.connected   = 1'b0;
							s.current_id  = NO_ID;
							s.match_count = '0;
						end else begin
							s.current_id = dec.id;
							if (cur.match_count < cfg.match_target) begin
								s.match_count = cur.match_count + 3'd1;
								s.wait_left   = 8'd0;
							end else begin
								s.connected = 1'b1;
								// A connected button is polled without pause.
								if (dec.id == BUTTON_ID) begin
									s.wait_left = 8'd0;
									s.button    = (sig_clean == BUTTON_SIG);
								end
							end
						end
					end
				end
				ST_ACT_SETUP: begin
					s.pu         = 1'b0;
					s.p6_mode    = P6_PULLUP;
					s.hold_timer = 8'd0;
					s.step       = ST_ACT_HOLD;
				end
				ST_ACT_HOLD: begin
					if (item.pin6_level) begin
						s.step = ST_START;
					end else if (s.hold_timer >= cfg.active_hold_ms) begin
						s.step = ST_ACT_ACCEPT;
					end
				end
				ST_ACT_ACCEPT: begin
					s.current_id = NO_ID;
					s.button     = 1'b0;
					s.connected  = 1'b1;
					s.step       = ST_HANDOFF;
				end
				ST_HANDOFF: begin
					if (item.restart_detect) begin
						s.step = ST_START;
					end
				end
				default: s.step = ST_START;
			endcase
		end
		nxt = s;
	end

endmodule

@@ rtl/port_device_id_detector_unit.sv @@
// Top level of the port device id detector: input register, state register and result register.
// Depends on pdd_pkg and pdd_step (which uses pdd_decode).
//
//   Channel   Signals                                   Direction  Moves on
//   item      item_valid, item_stall, item (pdd_in_t)   in         valid high, stall low
//   result    result_valid, result_stall, result        out        valid high, stall low
//   config    wr_en, wr_index, wr_data                  in         wr_en high
//
// Each accepted word is captured in the input register; once the result register is free, the step
// logic updates the detector state and loads the result register.
// A new word may be accepted every cycle while result_stall is low; the throughput is one word per
// clock, and each word reads and writes the single state register.
// Reset (arst_n low) puts the detector at the start of a passive pass with all pins as
// inputs, loads the register defaults and empties both pipeline registers.
// A stalled result holds the result register; the input register then holds its word and
// item_stall rises, so no word is lost or taken twice.
module port_device_id_detector_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  pdd_pkg::pdd_in_t item,
	output logic             result_valid,
	input  logic             result_stall,
	output pdd_pkg::pdd_out_t result,
	input  logic             wr_en,
	input  logic [1:0]       wr_index,
	input  logic [7:0]       wr_data
);
	import pdd_pkg::*;

	pdd_cfg_t   cfg_q;
	pdd_state_t state_q;
	pdd_state_t state_nxt;
	pdd_in_t    item_s1;
	logic       valid_s1;
	logic       out_free;
	logic       advance;
	logic       accept;

	// The result register can take a new word when it is empty or being read this cycle.
	assign out_free   = !result_valid || !result_stall;
	assign advance    = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;
	assign accept     = item_valid && !item_stall;

	// Configuration registers; user writes must come only while the detector is idle; unchecked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.settle_ms      <= 4'd2;
			cfg_q.repoll_ms      <= 8'd100;
			cfg_q.match_target   <= 3'd5;
			cfg_q.active_hold_ms <= 8'd100;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SETTLE:     cfg_q.settle_ms      <= wr_data[3:0];
				REG_REPOLL:     cfg_q.repoll_ms      <= wr_data;
				REG_MATCH:      cfg_q.match_target   <= wr_data[2:0];
				REG_ACTIVE_HLD: cfg_q.active_hold_ms <= wr_data;
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	pdd_step u_step (
		.cur  (state_q),
		.item (item_s1),
		.cfg  (cfg_q),
		.nxt  (state_nxt)
	);

	// Detector state advances once per word, as the word moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.step          <= ST_START;
			state_q.wait_left     <= '0;
			state_q.pattern_index <= '0;
			state_q.match_count   <= '0;
			state_q.signature     <= '0;
			state_q.current_id    <= NO_ID;
			state_q.connected     <= 1'b0;
			state_q.button        <= 1'b0;
			state_q.hold_timer    <= '0;
			state_q.tx            <= 1'b0;
			state_q.drv           <= 1'b0;
			state_q.pu            <= 1'b0;
			state_q.p6_mode       <= P6_INPUT;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result.tx_drive_level <= state_nxt.tx;
			result.pin5_driver_on <= state_nxt.drv;
			result.pin5_pullup    <= state_nxt.pu;
			result.pin6_mode      <= state_nxt.p6_mode;
			result.device_id      <= state_nxt.current_id;
			result.connected      <= state_nxt.connected;
			result.button_pressed <= state_nxt.button;
			result.active_handoff <= (state_nxt.step == ST_HANDOFF);
		end
	end

endmodule

@@ rtl/pdd_checker.sv @@
// Port-level assertions for the port device id detector, bound to the top level.
// Depends on pdd_pkg and port_device_id_detector_unit.
module pdd_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input logic              result_valid,
	input logic              result_stall,
	input pdd_pkg::pdd_out_t result
);
	import pdd_pkg::*;

	// A stalled result word stays offered and unchanged.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result word changed or dropped while stalled");

	// Handoff always shows a connected port with no passive id and no button.
	a_handoff_flags: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.active_handoff |->
			result.connected && result.device_id == NO_ID && !result.button_pressed)
		else $error("handoff shown with inconsistent id flags");

	// Only ids from the decode table ever appear.
	a_id_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.device_id <= MAX_ID)
		else $error("device id out of range");

	// The input side is never stalled while the result register is empty.
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid && item_valid |-> !item_stall)
		else $error("input stalled with an empty result register");

endmodule

bind port_device_id_detector_unit pdd_checker u_pdd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

@@ dv/tb_port_device_id_detector_unit.sv @@
// Self-checking testbench for port_device_id_detector_unit: directed words, then pin patterns
// shaped after device signatures, checked against an in-bench model of the detector.
// Depends on pdd_pkg and the detector RTL only.
module tb_port_device_id_detector_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import pdd_pkg::*;

	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 230;
	localparam int DIRECTED_ROWS   = 20;
	localparam int IDLE_PCT        = 12;
	localparam int DRAIN_CYCLES    = 8;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int PRINT_LIMIT     = 60;
	localparam int SIG_ENTRIES     = 14;
	localparam int FLOAT_ENTRY     = 13;

	// Internal marker for the float signature; it never appears on device_id.
	localparam logic [3:0] FLOAT_ID = 4'd15;

	// One row of the directed table: the word to send and, where it is obvious, the result.
	typedef struct packed {
		pdd_in_t  word;
		logic     typed;
		pdd_out_t want;
	} stim_row_t;

	logic     clk;
	logic     arst_n;
	logic     item_valid;
	logic     item_stall;
	pdd_in_t  item;
	logic     result_valid;
	logic     result_stall = 1'b0;
	pdd_out_t result;
	logic     wr_en;
	logic [1:0] wr_index;
	logic [7:0] wr_data;

	// Model of the detector: configuration copy and state, updated once per accepted word.
	pdd_cfg_t    cfg;
	pdd_step_t   det_step;
	logic [7:0]  det_wait;
	logic [3:0]  det_pat;
	logic [2:0]  det_matches;
	logic [SIG_W-1:0] det_sig;
	logic [3:0]  det_id;
	logic        det_conn;
	logic        det_btn;
	logic [7:0]  det_hold;
	logic        det_tx;
	logic        det_drv;
	logic        det_pu;
	logic [1:0]  det_p6;

	pdd_out_t pending_results[$];
	pdd_out_t oldest_result;
	int       mismatch_count = 0;
	int       cycle_count = 0;
	logic     calm = 1'b0;

	// Stimulus shaping: the signature the pins currently play back, and whether the
	// running active check should see pin 6 go high.
	logic [SIG_W-1:0] target_sig = '0;
	logic             hold_abort = 1'b0;

	port_device_id_detector_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Known signatures with the id they stand for, packed as {id, signature}.
	// The last entry is the float signature that starts an active check.
	function automatic logic [24:0] known_entry(input int k);
		case (k)
			0:  return {4'd0,  21'h0f303f};
			1:  return {4'd1,  21'h038007};
			2:  return {4'd2,  21'h0381ff};
			3:  return {4'd3,  21'h1c7000};
			4:  return {4'd4,  21'h038000};
			5:  return {4'd5,  21'h03f01f};
			6:  return {4'd5,  21'h03f00f};
			7:  return {4'd6,  21'h1ff1ff};
			8:  return {4'd7,  21'h1c7007};
			9:  return {4'd8,  21'h0e3007};
			10: return {4'd9,  21'h0fb1ff};
			11: return {4'd10, 21'h0c3000};
			12: return {4'd11, 21'h000024};
			default: return {FLOAT_ID, 21'h03803f};
		endcase
	endfunction

	function automatic logic [3:0] decode_signature(input logic [SIG_W-1:0] s);
		logic [24:0] e;
		for (int k = 0; k < SIG_ENTRIES; k++) begin
			e = known_entry(k);
			if (e[SIG_W-1:0] == s) return e[24:21];
		end
		return NO_ID;
	endfunction

	task automatic reset_detector_model();
		cfg.settle_ms      = 4'd2;
		cfg.repoll_ms      = 8'd100;
		cfg.match_target   = 3'd5;
		cfg.active_hold_ms = 8'd100;
		det_step    = ST_START;
		det_wait    = '0;
		det_pat     = '0;
		det_matches = '0;
		det_sig     = '0;
		det_id      = NO_ID;
		det_conn    = 1'b0;
		det_btn     = 1'b0;
		det_hold    = '0;
		det_tx      = 1'b0;
		det_drv     = 1'b0;
		det_pu      = 1'b0;
		det_p6      = P6_INPUT;
	endtask

	// End of a passive pass: release the pins, decode the signature and update the
	// match streak, the connected flag and the button flag.
	function automatic void close_pass();
		logic [3:0] found;
		det_drv = 1'b0;
		det_pu  = 1'b0;
		det_p6  = P6_INPUT;
		// Marginal receive bits: with this low half the upper half is not trusted.
		if (det_sig[11:0] == MARGINAL_LOW) det_sig[SIG_W-1:12] = '0;
		found = decode_signature(det_sig);
		if (found == FLOAT_ID) begin
			det_step = ST_ACT_SETUP;
		end else begin
			det_step = ST_START;
			det_wait = cfg.repoll_ms;
			if ((det_id != NO_ID && found != det_id) || found == NO_ID) begin
				det_conn    = 1'b0;
				det_id      = NO_ID;
				det_matches = '0;
			end else begin
				det_id = found;
				if (det_matches < cfg.match_target) begin
					det_matches = det_matches + 3'd1;
					det_wait    = '0;
				end else begin
					det_conn = 1'b1;
					// A connected button is polled without pause.
					if (found == BUTTON_ID) begin
						det_wait = '0;
						det_btn  = (det_sig == BUTTON_SIG);
					end
				end
			end
		end
	endfunction

	// Applies one word to the model and returns the result the detector should give.
	function automatic pdd_out_t advance_detector(input pdd_in_t w);
		pdd_out_t r;
		det_wait = (det_wait > 8'(w.elapsed_ms)) ? det_wait - 8'(w.elapsed_ms) : 8'd0;
		if (int'(det_hold) + int'(w.elapsed_ms) > 255) det_hold = 8'd255;
		else det_hold = det_hold + 8'(w.elapsed_ms);

		if (det_wait == 0) begin
			case (det_step)
				ST_START, ST_DRIVE: begin
					if (det_step == ST_START) begin
						det_sig = '0;
						det_pat = '0;
						det_pu  = 1'b1;
					end
					// Rows of the pattern grid set pin 5, columns set pin 6.
					case (det_pat)
						4'd0, 4'd1, 4'd2: begin
							det_tx  = 1'b1;
							det_drv = 1'b1;
						end
						4'd3, 4'd4, 4'd5: det_drv = 1'b0;
						4'd6, 4'd7, 4'd8: begin
							det_tx  = 1'b0;
							det_drv = 1'b1;
						end
						default: ;
					endcase
					det_p6   = 2'(det_pat % 3);
					det_wait = {4'd0, cfg.settle_ms};
					det_step = ST_SAMPLE;
				end
				ST_SAMPLE: begin
					if (w.pin5_level) det_sig[det_pat] = 1'b1;
					if (w.rx_level) det_sig[det_pat + RX_OFFSET] = 1'b1;
					det_pat  = det_pat + 4'd1;
					det_step = (det_pat < PATTERN_COUNT) ? ST_DRIVE : ST_DECODE;
				end
				ST_DECODE: close_pass();
				ST_ACT_SETUP: begin
					det_pu   = 1'b0;
					det_p6   = P6_PULLUP;
					det_hold = '0;
					det_step = ST_ACT_HOLD;
				end
				ST_ACT_HOLD: begin
					if (w.pin6_level) det_step = ST_START;
					else if (det_hold >= cfg.active_hold_ms) det_step = ST_ACT_ACCEPT;
				end
				ST_ACT_ACCEPT: begin
					det_id   = NO_ID;
					det_btn  = 1'b0;
					det_conn = 1'b1;
					det_step = ST_HANDOFF;
				end
				ST_HANDOFF: begin
					if (w.restart_detect) begin
						det_step = ST_START;
						det_wait = '0;
					end
				end
				default: det_step = ST_START;
			endcase
		end

		r.tx_drive_level = det_tx;
		r.pin5_driver_on = det_drv;
		r.pin5_pullup    = det_pu;
		r.pin6_mode      = det_p6;
		r.device_id      = det_id;
		r.connected      = det_conn;
		r.button_pressed = det_btn;
		r.active_handoff = (det_step == ST_HANDOFF);
		return r;
	endfunction

	// Directed table. Word bits after elapsed_ms are {pin5, rx, pin6, restart}.
	// Only the first two rows have their result typed in: right after reset the first
	// word drives pattern zero and the second lands inside the settle time, where a
	// restart outside handoff changes nothing.
	function automatic stim_row_t directed_row(input int n);
		stim_row_t r;
		r.want                = '0;
		r.want.tx_drive_level = 1'b1;
		r.want.pin5_driver_on = 1'b1;
		r.want.pin5_pullup    = 1'b1;
		r.want.pin6_mode      = P6_DRIVE_HIGH;
		r.typed               = 1'b0;
		case (n)
			0: begin
				r.word  = {3'd0, 4'b0000};
				r.typed = 1'b1;
			end
			1: begin
				r.word  = {3'd0, 4'b1111};
				r.typed = 1'b1;
			end
			2:  r.word = {3'd7, 4'b1000};
			3:  r.word = {3'd7, 4'b0100};
			4:  r.word = {3'd1, 4'b0010};
			5:  r.word = {3'd7, 4'b1100};
			6:  r.word = {3'd0, 4'b0001};
			7:  r.word = {3'd7, 4'b1110};
			8:  r.word = {3'd2, 4'b0000};
			9:  r.word = {3'd7, 4'b0111};
			10: r.word = {3'd4, 4'b1011};
			11: r.word = {3'd7, 4'b1101};
			12: r.word = {3'd3, 4'b0110};
			13: r.word = {3'd7, 4'b1001};
			14: r.word = {3'd5, 4'b0011};
			15: r.word = {3'd7, 4'b1010};
			16: r.word = {3'd6, 4'b0101};
			17: r.word = {3'd7, 4'b1111};
			18: r.word = {3'd0, 4'b0000};
			default: r.word = {3'd7, 4'b0001};
		endcase
		return r;
	endfunction

	// Chooses the signature that the pins play back during the next pass. Most passes
	// repeat the previous device so that match streaks build up and the port connects.
	task automatic pick_target();
		int r;
		logic [24:0] e;
		if (target_sig != '0 && $urandom_range(99) < 60) begin
			// A repeated button keeps flipping between its released and pressed forms.
			if (decode_signature(target_sig) == BUTTON_ID) begin
				e = known_entry(5 + $urandom_range(1));
				target_sig = e[SIG_W-1:0];
			end
		end else begin
			r = $urandom_range(99);
			if (r < 15) begin
				e = known_entry(FLOAT_ENTRY);
				target_sig = e[SIG_W-1:0];
			end else if (r < 25) begin
				target_sig = {9'($urandom), MARGINAL_LOW};
			end else if (r < 32) begin
				target_sig = 21'($urandom);
			end else if (r < 50) begin
				e = known_entry(5 + $urandom_range(1));
				target_sig = e[SIG_W-1:0];
			end else begin
				e = known_entry($urandom_range(12));
				target_sig = e[SIG_W-1:0];
			end
		end
	endtask

	// Builds the next word from the model's current state: sample slots read the target
	// signature with a little noise, pin 6 stays low through an active check unless that
	// check is meant to fail, and restart is rare inside handoff.
	function automatic pdd_in_t make_word();
		pdd_in_t w;
		int r;
		r = $urandom_range(99);
		if (r < 25) w.elapsed_ms = 3'd0;
		else if (r < 70) w.elapsed_ms = 3'd1;
		else w.elapsed_ms = 3'($urandom_range(7, 2));
		if (det_pat < PATTERN_COUNT) begin
			w.pin5_level = target_sig[det_pat];
			w.rx_level   = target_sig[det_pat + RX_OFFSET];
		end else begin
			w.pin5_level = 1'($urandom);
			w.rx_level   = 1'($urandom);
		end
		if ($urandom_range(99) < 3) w.pin5_level = ~w.pin5_level;
		if ($urandom_range(99) < 3) w.rx_level = ~w.rx_level;
		if (det_step == ST_ACT_HOLD) w.pin6_level = hold_abort && ($urandom_range(9) == 0);
		else w.pin6_level = 1'($urandom);
		if (det_step == ST_HANDOFF) w.restart_detect = ($urandom_range(19) == 0);
		else w.restart_detect = ($urandom_range(9) == 0);
		return w;
	endfunction

	// Register settings per phase: the low and high extremes, all zero, a few fixed
	// mixes and two random ones.
	function automatic pdd_cfg_t phase_setting(input int ph);
		pdd_cfg_t c;
		case (ph)
			1: c = {4'd1, 8'd1, 3'd1, 8'd1};
			2: c = {4'd0, 8'd0, 3'd0, 8'd0};
			3: c = {4'd15, 8'd255, 3'd7, 8'd255};
			4: c = {4'd3, 8'd20, 3'd2, 8'd10};
			6: c = {4'd1, 8'd5, 3'd3, 8'd40};
			default: begin
				c.settle_ms      = 4'($urandom);
				c.repoll_ms      = 8'($urandom);
				c.match_target   = 3'($urandom);
				c.active_hold_ms = 8'($urandom);
			end
		endcase
		return c;
	endfunction

	// Predicts the word's result, queues it (or the typed value), then offers the word
	// after a random gap and holds it until the detector takes it.
	task automatic send_word(input pdd_in_t w, input logic typed, input pdd_out_t want);
		pdd_out_t guess;
		guess = advance_detector(w);
		pending_results.push_back(typed ? want : guess);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item       <= w;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	// Stops sending and waits until every queued result has been taken.
	task automatic drain_results();
		item_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// Writes all four registers on consecutive cycles; only called with the detector idle.
	task automatic write_config(input pdd_cfg_t c);
		wr_en    <= 1'b1;
		wr_index <= REG_SETTLE;
		wr_data  <= {4'd0, c.settle_ms};
		@(posedge clk);
		wr_index <= REG_REPOLL;
		wr_data  <= c.repoll_ms;
		@(posedge clk);
		wr_index <= REG_MATCH;
		wr_data  <= {5'd0, c.match_target};
		@(posedge clk);
		wr_index <= REG_ACTIVE_HLD;
		wr_data  <= c.active_hold_ms;
		@(posedge clk);
		wr_en <= 1'b0;
		cfg = c;
	endtask

	task automatic check_field(input string name, input logic [3:0] want, input logic [3:0] got);
		if (want !== got) begin
			if (mismatch_count < PRINT_LIMIT)
				$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// The receiver stalls at random except during the calm phase.
	always @(posedge clk) begin
		result_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
	end

	// Every result taken from the detector is matched against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				if (mismatch_count < PRINT_LIMIT)
					$display("%0t ns: result %h arrived with nothing expected", $time, result);
				mismatch_count++;
			end else begin
				oldest_result = pending_results.pop_front();
				check_field("tx_drive_level", 4'(oldest_result.tx_drive_level),
					4'(result.tx_drive_level));
				check_field("pin5_driver_on", 4'(oldest_result.pin5_driver_on),
					4'(result.pin5_driver_on));
				check_field("pin5_pullup", 4'(oldest_result.pin5_pullup),
					4'(result.pin5_pullup));
				check_field("pin6_mode", 4'(oldest_result.pin6_mode), 4'(result.pin6_mode));
				check_field("device_id", oldest_result.device_id, result.device_id);
				check_field("connected", 4'(oldest_result.connected), 4'(result.connected));
				check_field("button_pressed", 4'(oldest_result.button_pressed),
					4'(result.button_pressed));
				check_field("active_handoff", 4'(oldest_result.active_handoff),
					4'(result.active_handoff));
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		pdd_step_t prev_step;
		stim_row_t row;

		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		wr_en      = 1'b0;
		wr_index   = REG_SETTLE;
		wr_data    = '0;
		reset_detector_model();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < PHASES; ph++) begin
			// Between phases the sender waits for every result, so the new settings
			// land on an idle detector; its pass state carries over on purpose.
			if (ph > 0) begin
				drain_results();
				write_config(phase_setting(ph));
			end
			// One phase runs with no idling on either side.
			calm <= (ph == 4);

			if (ph == 0) begin
				for (int n = 0; n < DIRECTED_ROWS; n++) begin
					row = directed_row(n);
					send_word(row.word, row.typed, row.want);
				end
				pick_target();
			end

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				prev_step = det_step;
				send_word(make_word(), 1'b0, '0);
				if (det_step == ST_START && prev_step != ST_START) pick_target();
				if (det_step == ST_ACT_SETUP && prev_step != ST_ACT_SETUP)
					hold_abort = ($urandom_range(4) == 0);
			end
		end

		drain_results();
		// Keep clocking for a while so that any stray extra result is caught.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
